// File: design/bic_pkg.sv
// Shared types and constants for the binary image centroid block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bic_pkg;

  // Default frame limits handed to the top level parameters.
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Fixed field and accumulator widths.
  localparam int PIX_W      = 8;
  localparam int FW_W       = 13;
  localparam int SUM_W      = 32;
  localparam int MOM_W      = 44;
  localparam int POS_W      = 13;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  // Compare width that holds both the next column and the largest column limit.
  localparam int CMP_W = 14;

  // One quotient bit per divider step.
  localparam int DIV_STEPS = MOM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Register reset values.
  localparam logic [FW_W-1:0]  FW_RESET  = FW_W'(640);
  localparam logic [SUM_W-1:0] THR_RESET = SUM_W'(10000);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH    = 1'b0,
    CFG_AREA_THRESHOLD = 1'b1
  } cfg_idx_e;

  // Moment sums of the frame in progress.
  typedef struct packed {
    logic [SUM_W-1:0] m00;
    logic [MOM_W-1:0] m10;
    logic [MOM_W-1:0] m01;
  } moments_t;

endpackage

// File: design/binary_image_centroid.sv
// Binary image centroid: pixels accumulate at one word per cycle while in_ready_o is high.
// On the last word of a frame the block stops accepting while it runs the check state,
// two passes of the shared one-bit-per-cycle divider, then the result load.
// Without an object the divider is skipped and the check state goes straight to the result load.
// Reset (asynchronous, active low) clears counters, sums and the output valid flag, and loads
// frame_width = 640 and area_threshold = 10000.
`timescale 1ns / 1ps

module binary_image_centroid import bic_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIX_W-1:0]      pixel_i,
  input  logic                  last_of_frame_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  found_o,
  output logic [POS_W-1:0]      pos_x_o,
  output logic [POS_W-1:0]      pos_y_o
);

  typedef enum logic [4:0] {
    ST_ACC  = 5'b00001,
    ST_CHK  = 5'b00010,
    ST_DIVX = 5'b00100,
    ST_DIVY = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [FW_W-1:0]  frame_width_q;
  logic [SUM_W-1:0] area_thr_q;
  moments_t         moments;
  logic             take;
  logic             clear;
  logic             div_start;
  logic             div_done;
  logic [MOM_W-1:0] dividend;
  logic [MOM_W-1:0] quotient;
  logic [POS_W-1:0] quo_x_clamp, quo_y_clamp;
  logic             found_q, found_d;
  logic [POS_W-1:0] qx_q, qx_d, qy_q, qy_d;
  logic             out_valid_q, out_valid_d;
  logic             load_out;
  logic             out_free;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q <= FW_RESET;
      area_thr_q    <= THR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:    frame_width_q <= cfg_data_i[FW_W-1:0];
        CFG_AREA_THRESHOLD: area_thr_q    <= cfg_data_i[SUM_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_ACC);
  assign take       = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign load_out   = (state_q == ST_EMIT) && out_free;
  assign clear      = load_out;

  bic_accum #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .clear_i       (clear),
    .pixel_i       (pixel_i),
    .frame_width_i (frame_width_q),
    .moments_o     (moments)
  );

  // The x pass starts from the check state, the y pass when the x pass ends.
  assign dividend  = (state_q == ST_DIVX) ? moments.m01 : moments.m10;
  assign div_start = ((state_q == ST_CHK) && (moments.m00 > area_thr_q)) ||
                     ((state_q == ST_DIVX) && div_done);

  bic_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (moments.m00),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Quotients beyond the largest supported frame clamp to the last supported column or row.
  assign quo_x_clamp = (quotient > MOM_W'(MAX_WIDTH - 1)) ?
                       POS_W'(MAX_WIDTH - 1) : quotient[POS_W-1:0];
  assign quo_y_clamp = (quotient > MOM_W'(MAX_HEIGHT - 1)) ?
                       POS_W'(MAX_HEIGHT - 1) : quotient[POS_W-1:0];

  // Frame-end sequencer.
  always_comb begin
    state_d = state_q;
    found_d = found_q;
    qx_d    = qx_q;
    qy_d    = qy_q;
    case (state_q)
      ST_ACC: begin
        if (take && last_of_frame_i) begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        found_d = moments.m00 > area_thr_q;
        qx_d    = '1;
        qy_d    = '1;
        state_d = (moments.m00 > area_thr_q) ? ST_DIVX : ST_EMIT;
      end
      ST_DIVX: begin
        if (div_done) begin
          qx_d    = quo_x_clamp;
          state_d = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (div_done) begin
          qy_d    = quo_y_clamp;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_ACC;
        end
      end
      default: state_d = ST_ACC;
    endcase
  end

  // Output register holds the result until it is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    qx_q    <= qx_d;
    qy_q    <= qy_d;
    if (load_out) begin
      found_o <= found_q;
      pos_x_o <= qx_q;
      pos_y_o <= qy_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // A divider result only arrives during one of the two division passes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIVX || state_q == ST_DIVY))
    else $error("divider finished outside a division pass");

  // The last word of a frame always leads into the check state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && last_of_frame_i) |=> (state_q == ST_CHK))
    else $error("frame end did not start the result sequence");

  // A result without an object reports all ones in both coordinates.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (pos_x_o == '1 && pos_y_o == '1))
    else $error("empty frame reported a position");

endmodule

// File: design/bic_accum.sv
// Column and row tracking plus saturating moment accumulators.
// Depends on bic_pkg for widths and the moments_t struct.
`timescale 1ns / 1ps

module bic_accum import bic_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic             clear_i,
  input  logic [PIX_W-1:0] pixel_i,
  input  logic [FW_W-1:0]  frame_width_i,
  output moments_t         moments_o
);

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int RW      = $clog2(MAX_HEIGHT);
  localparam int PROD_XW = PIX_W + CW;
  localparam int PROD_YW = PIX_W + RW;

  logic [CW-1:0]    col_q, col_d;
  logic [RW-1:0]    row_q, row_d;
  moments_t         mom_q, mom_d;
  logic [CW:0]      next_col;
  logic             wrap;
  logic [PROD_XW-1:0] prod_x;
  logic [PROD_YW-1:0] prod_y;
  logic [SUM_W:0]   add_i;
  logic [MOM_W:0]   add_x;
  logic [MOM_W:0]   add_y;

  // Weighted contributions of the current word.
  assign prod_x = PROD_XW'(pixel_i) * PROD_XW'(col_q);
  assign prod_y = PROD_YW'(pixel_i) * PROD_YW'(row_q);

  // Sums carry one extra bit; a carry means the limit was passed.
  assign add_i = (SUM_W+1)'(mom_q.m00) + (SUM_W+1)'(pixel_i);
  assign add_x = (MOM_W+1)'(mom_q.m10) + (MOM_W+1)'(prod_x);
  assign add_y = (MOM_W+1)'(mom_q.m01) + (MOM_W+1)'(prod_y);

  // The column wraps at the frame width or at the largest supported width.
  assign next_col = {1'b0, col_q} + 1'b1;
  assign wrap = (CMP_W'(next_col) >= CMP_W'(frame_width_i)) ||
                (CMP_W'(next_col) >= CMP_W'(MAX_WIDTH));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    mom_d = mom_q;
    if (clear_i) begin
      col_d = '0;
      row_d = '0;
      mom_d = '0;
    end else if (take_i) begin
      mom_d.m00 = add_i[SUM_W] ? '1 : add_i[SUM_W-1:0];
      mom_d.m10 = add_x[MOM_W] ? '1 : add_x[MOM_W-1:0];
      mom_d.m01 = add_y[MOM_W] ? '1 : add_y[MOM_W-1:0];
      if (wrap) begin
        col_d = '0;
        // Rows saturate at the last supported row.
        if (row_q < RW'(MAX_HEIGHT - 1)) begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = next_col[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      mom_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      mom_q <= mom_d;
    end
  end

  assign moments_o = mom_q;

endmodule

// File: design/bic_div.sv
// Restoring divider that produces one quotient bit per cycle.
// Depends on bic_pkg for operand widths and the step count.
`timescale 1ns / 1ps

module bic_div import bic_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MOM_W-1:0] dividend_i,
  input  logic [SUM_W-1:0] divisor_i,
  output logic             done_o,
  output logic [MOM_W-1:0] quotient_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0]     rem_q, rem_d;
  logic [MOM_W-1:0]     quo_q, quo_d;
  logic [SUM_W-1:0]     dsr_q, dsr_d;
  logic [SUM_W:0]       rem_sh;
  logic [SUM_W:0]       diff;
  logic                 ge;

  // Shift in the next dividend bit and try a subtraction.
  assign rem_sh = {rem_q, quo_q[MOM_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};
  assign diff   = rem_sh - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_STEPS - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];
      quo_d = {quo_q[MOM_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and quotient registers carry no reset.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
